/* rtl/core/pun_pkg.sv */
// Shared constants, types and helpers of the partition-of-unity normalizer.
package pun_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned Lanes     = 4;
  localparam int unsigned InW       = 24;
  localparam int unsigned NormW     = FracBits + 1;
  localparam int unsigned SumW      = NormW + $clog2(Lanes);
  localparam int unsigned CntW      = 3;
  localparam int unsigned BitsPerSt = 3;
  localparam int unsigned DivStages = (NormW + BitsPerSt - 1) / BitsPerSt;
  localparam logic [NormW-1:0] One  = NormW'(1) << FracBits;

  typedef struct packed {
    logic [Lanes-1:0][SumW-1:0]  rem;
    logic [Lanes-1:0]            lsb;
    logic [Lanes-1:0][NormW-1:0] quo;
    logic [SumW-1:0]             divisor;
  } pun_item_t;

endpackage

/* rtl/core/partition_of_unity_normalizer_core.sv */
// Top level of the partition-of-unity normalizer: clamp, sum and pipelined divide.
//
// Takes one voxel of four signed components (16 fraction bits, 65536 = 1.0)
// per request and returns four unsigned normalized components: each component
// in use is clamped to [0,1] and divided, truncating, by max(1, sum of the
// clamped components); components beyond components_in_use read as zero.
// An item may enter every cycle unless the output stalls; one clamp-and-sum
// stage is followed by six restoring-division stages that produce three
// quotient bits each (two in the last), all four lanes in parallel. Each
// stage holds its item while the next cannot take it, so a stall on the
// master side backs up without loss, and bubbles are squeezed out. The user must
// write components_in_use through cfg_we_i/cfg_wdata_i only while the pipeline
// is empty; the block does not enforce this. Values above four act as four.
module partition_of_unity_normalizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // comp0[23:0], comp1, comp2, comp3
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // norm0[16:0], norm1, norm2, norm3, zero pad
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i
);

  localparam int unsigned NS = pun_pkg::DivStages;

  logic [pun_pkg::CntW-1:0] count_q;
  logic [pun_pkg::Lanes-1:0][pun_pkg::InW-1:0] comp;

  logic               valid [NS+1];
  logic               ready [NS+1];
  pun_pkg::pun_item_t item  [NS+1];

  // hold the count; reset gives all four components
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= pun_pkg::CntW'(pun_pkg::Lanes);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign comp = s_axis_tdata;

  pun_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .comp_i  (comp),
    .count_i (count_q),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .item_o  (item[0])
  );

  // chain the division stages, most significant quotient bits first
  for (genvar s = 0; s < NS; s++) begin : g_div
    localparam int unsigned First = pun_pkg::NormW - 1 - s * pun_pkg::BitsPerSt;
    localparam int unsigned Nb    = (First + 1 < pun_pkg::BitsPerSt) ? First + 1
                                                                      : pun_pkg::BitsPerSt;
    pun_div_stage #(
      .FIRST_BIT (First),
      .NUM_BITS  (Nb)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[s]),
      .ready_o (ready[s]),
      .item_i  (item[s]),
      .valid_o (valid[s+1]),
      .ready_i (ready[s+1]),
      .item_o  (item[s+1])
    );
  end

  assign ready[NS]     = m_axis_tready;
  assign m_axis_tvalid = valid[NS];

  // pack the quotients, pad the top four bits with zeros
  always_comb begin
    m_axis_tdata = '0;
    for (int k = 0; k < pun_pkg::Lanes; k++) begin
      m_axis_tdata[k*pun_pkg::NormW +: pun_pkg::NormW] = item[NS].quo[k];
    end
  end

endmodule

/* rtl/core/pun_front.sv */
// Front stage: clamp components, sum them and set up the divider state.
module pun_front (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  output logic                                          ready_o,
  input  logic [pun_pkg::Lanes-1:0][pun_pkg::InW-1:0]  comp_i,
  input  logic [pun_pkg::CntW-1:0]                      count_i,
  output logic                                          valid_o,
  input  logic                                          ready_i,
  output pun_pkg::pun_item_t                            item_o
);

  logic               valid_q;
  pun_pkg::pun_item_t item_q, item_d;
  logic [pun_pkg::CntW-1:0] active;
  logic [pun_pkg::Lanes-1:0][pun_pkg::NormW-1:0] clamped;
  logic [pun_pkg::SumW-1:0] sum;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    active = (count_i > pun_pkg::CntW'(pun_pkg::Lanes)) ? pun_pkg::CntW'(pun_pkg::Lanes)
                                                        : count_i;
    sum = '0;
    for (int k = 0; k < pun_pkg::Lanes; k++) begin
      if (pun_pkg::CntW'(k) >= active || comp_i[k][pun_pkg::InW-1]) begin
        clamped[k] = '0;
      end else if (comp_i[k] > pun_pkg::InW'(pun_pkg::One)) begin
        clamped[k] = pun_pkg::One;
      end else begin
        clamped[k] = comp_i[k][pun_pkg::NormW-1:0];
      end
      sum = sum + pun_pkg::SumW'(clamped[k]);
    end
    item_d.divisor = (sum >= pun_pkg::SumW'(pun_pkg::One)) ? sum : pun_pkg::SumW'(pun_pkg::One);
    for (int k = 0; k < pun_pkg::Lanes; k++) begin
      item_d.rem[k] = pun_pkg::SumW'(clamped[k] >> 1);
      item_d.lsb[k] = clamped[k][0];
      item_d.quo[k] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

/* rtl/core/pun_div_stage.sv */
// One restoring-division stage: NUM_BITS quotient bits for every lane.
module pun_div_stage #(
  parameter int unsigned FIRST_BIT = 16,
  parameter int unsigned NUM_BITS  = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  pun_pkg::pun_item_t item_i,
  output logic               valid_o,
  input  logic               ready_i,
  output pun_pkg::pun_item_t item_o
);

  logic               valid_q;
  pun_pkg::pun_item_t item_q, item_d;
  logic [pun_pkg::SumW:0] trial;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    item_d = item_i;
    trial  = '0;
    for (int k = 0; k < pun_pkg::Lanes; k++) begin
      for (int b = 0; b < NUM_BITS; b++) begin
        // bring in the dividend bit: only the top quotient bit sees the lsb
        trial = {item_d.rem[k],
                 (FIRST_BIT - b == pun_pkg::FracBits) ? item_d.lsb[k] : 1'b0};
        if (trial >= {1'b0, item_d.divisor}) begin
          trial = trial - {1'b0, item_d.divisor};
          item_d.quo[k] = {item_d.quo[k][pun_pkg::NormW-2:0], 1'b1};
        end else begin
          item_d.quo[k] = {item_d.quo[k][pun_pkg::NormW-2:0], 1'b0};
        end
        item_d.rem[k] = trial[pun_pkg::SumW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

/* rtl/core/pun_checker.sv */
// Port-level checker of the normalizer and its bind to the top level.
module pun_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output request dropped or changed under stall");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[71:68] == 4'd0)
    else $error("output padding not zero");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[16:0] <= 17'd65536) && (m_axis_tdata[33:17] <= 17'd65536)
                   && (m_axis_tdata[50:34] <= 17'd65536) && (m_axis_tdata[67:51] <= 17'd65536))
    else $error("normalized component above one");

  a_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output request right after reset");

endmodule

bind partition_of_unity_normalizer_core pun_checker u_pun_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
